// ----- sv/ufem_pkg.sv -----
`default_nettype none
package ufem_pkg;

   localparam int NODE_W   = 10;
   localparam int NODES    = 1 << NODE_W;
   localparam int SIZE_W   = NODE_W + 1;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 32;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_EDGE  = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight_a;
      logic [WEIGHT_W-1:0] weight_b;
   } req_type;

   typedef struct packed {
      logic             joined;
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] parent;
      logic [SIZE_W-1:0] size;
   } node_word_type;

endpackage
`default_nettype wire

// ----- sv/union_find_edge_merger_unit.sv -----
`default_nettype none
// Kruskal merge engine over a union-find forest (union by size, full path
// compression). One request at a time: a clear request sweeps the node memory,
// one entry a cycle; the same sweep runs after reset, during which no request
// is taken. An edge request walks from each endpoint to its root and then
// compresses the path, links the two roots when they differ, and skips the
// link when the endpoints already share a root; each link on a path is one
// read of the single node memory, once for the root search and once for the
// compression pass.
// A finished response waits in an output register while the next request runs.
module union_find_edge_merger_unit
   import ufem_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WALK  = 7'b0000100,
      ST_COMP  = 7'b0001000,
      ST_LINK  = 7'b0010000,
      ST_ROOT  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   node_word_type mem [NODES];
   node_word_type rd_data_ff;
   logic [NODE_W-1:0] rd_addr;
   logic              mem_we;
   logic [NODE_W-1:0] mem_waddr;
   node_word_type     mem_wdata;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [NODE_W-1:0] sweep_ff, sweep_in;
   logic [NODE_W-1:0] walk_ff, walk_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic              phase_ff, phase_in;
   logic [NODE_W-1:0] root_a_ff, root_a_in, root_b_ff, root_b_in;
   logic [SIZE_W-1:0] size_a_ff, size_a_in, size_b_ff, size_b_in;
   logic [NODE_W-1:0] big_ff, big_in;
   logic [SUM_W-1:0]  total_a_ff, total_a_in, total_b_ff, total_b_in;
   logic              joined_ff, joined_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [NODE_W-1:0] link;
   logic [NODE_W-1:0] root_cur;
   logic [SIZE_W-1:0] root_size;
   logic [SUM_W:0]    add_a, add_b;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign link      = rd_data_ff.valid ? rd_data_ff.parent : walk_ff;
   assign root_cur  = phase_ff ? root_b_ff : root_a_ff;
   assign root_size = rd_data_ff.valid ? rd_data_ff.size : SIZE_W'(1);
   assign add_a = {1'b0, total_a_ff} + {{(SUM_W-WEIGHT_W+1){1'b0}}, req_ff.weight_a};
   assign add_b = {1'b0, total_b_ff} + {{(SUM_W-WEIGHT_W+1){1'b0}}, req_ff.weight_b};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sweep_in     = sweep_ff;
      walk_in      = walk_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      size_a_in    = size_a_ff;
      size_b_in    = size_b_ff;
      big_in       = big_ff;
      total_a_in   = total_a_ff;
      total_b_in   = total_b_ff;
      joined_in    = joined_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = walk_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = rd_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = sweep_ff;
            mem_wdata    = '0;
            sweep_in     = sweep_ff + NODE_W'(1);
            if (sweep_ff == NODE_W'(NODES - 1)) begin
               state_in = pend_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               joined_in = 1'b0;
               pend_in   = 1'b1;
               if (req_data.opcode == OP_CLEAR) begin
                  total_a_in = '0;
                  total_b_in = '0;
                  sweep_in   = '0;
                  state_in   = ST_CLEAR;
               end else begin
                  rd_addr  = req_data.node_a;
                  walk_in  = req_data.node_a;
                  phase_in = 1'b0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (link == walk_ff) begin
               if (phase_ff) begin
                  root_b_in = walk_ff;
                  size_b_in = root_size;
                  rd_addr   = req_ff.node_b;
                  cur_in    = req_ff.node_b;
               end else begin
                  root_a_in = walk_ff;
                  size_a_in = root_size;
                  rd_addr   = req_ff.node_a;
                  cur_in    = req_ff.node_a;
               end
               state_in = ST_COMP;
            end else begin
               rd_addr = link;
               walk_in = link;
            end
         end
         ST_COMP: begin
            if (cur_ff == root_cur) begin
               if (!phase_ff) begin
                  rd_addr  = req_ff.node_b;
                  walk_in  = req_ff.node_b;
                  phase_in = 1'b1;
                  state_in = ST_WALK;
               end else if (root_a_ff == root_b_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LINK;
               end
            end else begin
               // path node: point straight at the root, keep valid and size
               mem_we           = 1'b1;
               mem_waddr        = cur_ff;
               mem_wdata.parent = root_cur;
               rd_addr          = rd_data_ff.parent;
               cur_in           = rd_data_ff.parent;
            end
         end
         ST_LINK: begin
            mem_we = 1'b1;
            if (size_a_ff < size_b_ff) begin
               big_in    = root_b_ff;
               mem_waddr = root_a_ff;
               mem_wdata = '{valid: 1'b1, parent: root_b_ff, size: size_a_ff};
            end else begin
               big_in    = root_a_ff;
               mem_waddr = root_b_ff;
               mem_wdata = '{valid: 1'b1, parent: root_a_ff, size: size_b_ff};
            end
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            mem_we     = 1'b1;
            mem_waddr  = big_ff;
            mem_wdata  = '{valid: 1'b1, parent: big_ff, size: size_a_ff + size_b_ff};
            total_a_in = add_a[SUM_W] ? {SUM_W{1'b1}} : add_a[SUM_W-1:0];
            total_b_in = add_b[SUM_W] ? {SUM_W{1'b1}} : add_b[SUM_W-1:0];
            joined_in  = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{joined: joined_ff, sum_a: total_a_ff, sum_b: total_b_ff};
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_a_ff   <= '0;
         total_b_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         total_a_ff   <= total_a_in;
         total_b_ff   <= total_b_in;
      end
      req_ff      <= req_in;
      walk_ff     <= walk_in;
      cur_ff      <= cur_in;
      phase_ff    <= phase_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      size_a_ff   <= size_a_in;
      size_b_ff   <= size_b_in;
      big_ff      <= big_in;
      joined_ff   <= joined_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- verif/union_find_edge_merger_unit_test.sv -----
`timescale 1ns / 100ps
module union_find_edge_merger_unit_test
   import ufem_pkg::*;
();

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   union_find_edge_merger_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // forest mirror
   logic [NODE_W-1:0] up_link [NODES];
   logic [SIZE_W-1:0] span    [NODES];
   bit                linked  [NODES];
   logic [SUM_W-1:0]  run_a = '0;
   logic [SUM_W-1:0]  run_b = '0;

   rsp_type awaited_merges [$];
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cycles        = 0;
   int mismatches    = 0;
   int edges_sent    = 0;
   int clears_sent   = 0;
   int merges_made   = 0;

   function automatic logic [NODE_W-1:0] link_of_node(input logic [NODE_W-1:0] n);
      return linked[n] ? up_link[n] : n;
   endfunction

   function automatic logic [SIZE_W-1:0] size_of_root(input logic [NODE_W-1:0] n);
      return linked[n] ? span[n] : SIZE_W'(1);
   endfunction

   function automatic logic [NODE_W-1:0] find_and_flatten(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nxt;
      int steps;
      root = n;
      steps = 0;
      while (steps < NODES && link_of_node(root) != root) begin
         root = link_of_node(root);
         steps++;
      end
      cur = n;
      steps = 0;
      while (steps < NODES && cur != root) begin
         nxt = link_of_node(cur);
         up_link[cur] = root;
         cur = nxt;
         steps++;
      end
      return root;
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
                                                input logic [WEIGHT_W-1:0] w);
      logic [SUM_W:0] t;
      t = {1'b0, s} + (SUM_W+1)'(w);
      return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
   endfunction

   function automatic rsp_type merge_outcome(input req_type r);
      rsp_type           o;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
      logic [NODE_W-1:0] tn;
      logic [SIZE_W-1:0] sa;
      logic [SIZE_W-1:0] sb;
      logic [SIZE_W-1:0] ts;
      o = '0;
      if (r.opcode == OP_CLEAR) begin
         foreach (linked[i]) linked[i] = 1'b0;
         run_a = '0;
         run_b = '0;
      end else begin
         ra = find_and_flatten(r.node_a);
         rb = find_and_flatten(r.node_b);
         if (ra != rb) begin
            sa = size_of_root(ra);
            sb = size_of_root(rb);
            if (sa < sb) begin
               tn = ra; ra = rb; rb = tn;
               ts = sa; sa = sb; sb = ts;
            end
            up_link[rb] = ra;
            span[rb]    = sb;
            linked[rb]  = 1'b1;
            up_link[ra] = ra;
            span[ra]    = sa + sb;
            linked[ra]  = 1'b1;
            run_a = sat_sum(run_a, r.weight_a);
            run_b = sat_sum(run_b, r.weight_b);
            o.joined = 1'b1;
         end
      end
      o.sum_a = run_a;
      o.sum_b = run_b;
      return o;
   endfunction

   function automatic req_type make_request(input logic op, input int a, input int b,
                                            input int wa, input int wb);
      req_type r;
      r.opcode   = op;
      r.node_a   = NODE_W'(a);
      r.node_b   = NODE_W'(b);
      r.weight_a = WEIGHT_W'(wa);
      r.weight_b = WEIGHT_W'(wb);
      return r;
   endfunction

   // receiver: random stall, or a counted hold-off when asked for
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_merges.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result joined=%0b sum_a=%h sum_b=%h", $time,
                     rsp_data.joined, rsp_data.sum_a, rsp_data.sum_b);
         end else begin
            want = awaited_merges.pop_front();
            if (rsp_data.joined !== want.joined) begin
               mismatches++;
               $display("%0t: joined expected %0b actual %0b", $time, want.joined,
                        rsp_data.joined);
            end
            if (rsp_data.sum_a !== want.sum_a) begin
               mismatches++;
               $display("%0t: sum_a expected %h actual %h", $time, want.sum_a,
                        rsp_data.sum_a);
            end
            if (rsp_data.sum_b !== want.sum_b) begin
               mismatches++;
               $display("%0t: sum_b expected %h actual %h", $time, want.sum_b,
                        rsp_data.sum_b);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  awaited_merges.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_request(input req_type r);
      rsp_type o;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      o = merge_outcome(r);
      awaited_merges = {awaited_merges, o};
      if (r.opcode == OP_CLEAR) clears_sent++;
      else edges_sent++;
      if (o.joined) merges_made++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_merges.size() != 0);
   endtask

   function automatic logic [NODE_W-1:0] pick_node(input int base, input int pool);
      if ($urandom_range(3) != 0)
         return NODE_W'((base + $urandom_range(pool - 1)) % NODES);
      return NODE_W'($urandom);
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      idle_pct  = 20;
      stall_pct = 20;
      send_request(make_request(OP_CLEAR, 0, 0, 0, 0));
      send_request(make_request(OP_EDGE, 0, 1023, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_EDGE, 1023, 0, 16'h1234, 16'h4321));   // same root
      send_request(make_request(OP_EDGE, 5, 5, 16'hFFFF, 16'h0001));      // self loop
      send_request(make_request(OP_EDGE, 2, 3, 0, 0));
      send_request(make_request(OP_EDGE, 0, 2, 16'h0001, 16'h8000));      // equal sizes
      send_request(make_request(OP_EDGE, 3, 1023, 7, 9));
      send_request(make_request(OP_EDGE, 4, 3, 16'h5555, 16'hAAAA));      // smaller first
      send_request(make_request(OP_EDGE, 10'h155, 10'h2AA, 16'hAAAA, 16'h5555));
      send_request(make_request(OP_EDGE, 10'h2AA, 10'h155, 1, 1));
      send_request(make_request(OP_EDGE, 10'h155, 4, 0, 16'hFFFF));
      send_request(make_request(OP_EDGE, 1023, 10'h2AA, 3, 3));
      send_request(make_request(OP_CLEAR, 1023, 1023, 16'hFFFF, 16'hFFFF));
      send_request(make_request(OP_EDGE, 1023, 0, 16'hFFFF, 0));
      send_request(make_request(OP_EDGE, 0, 1023, 1, 1));
      send_request(make_request(OP_CLEAR, 0, 0, 0, 0));
      wait_drain();
   endtask

   // pairwise merging of the whole node space: deepest trees, size 1024 at the root
   task automatic test_full_merge();
      idle_pct  = 10;
      stall_pct = 10;
      send_request(make_request(OP_CLEAR, 0, 0, 0, 0));
      for (int step = 1; step < NODES; step = step * 2)
         for (int i = 0; i < NODES; i = i + 2 * step)
            send_request(make_request(OP_EDGE, i + step, i, $urandom, $urandom));
      for (int i = 0; i < 8; i++)
         send_request(make_request(OP_EDGE, $urandom, $urandom, $urandom, $urandom));
      wait_drain();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 16; i++)
         send_request(make_request(OP_EDGE, $urandom_range(15), $urandom_range(15),
                                   $urandom, $urandom));
      wait_drain();
   endtask

   task automatic test_random(input int count, input int gap_pct, input int hold_pct);
      int      base;
      int      pool;
      req_type r;
      idle_pct  = gap_pct;
      stall_pct = hold_pct;
      base = 0;
      pool = 8;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            base = $urandom_range(NODES - 1);
            pool = 1 << $urandom_range(2, 7);
         end
         r.opcode   = ($urandom_range(119) == 0) ? OP_CLEAR : OP_EDGE;
         r.node_a   = pick_node(base, pool);
         r.node_b   = ($urandom_range(19) == 0) ? r.node_a : pick_node(base, pool);
         r.weight_a = pick_weight();
         r.weight_b = pick_weight();
         send_request(r);
      end
      wait_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_merge();
      test_backpressure();
      test_random(180, 7, 56);
      test_random(180, 56, 7);
      test_random(180, 0, 0);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d edge requests (%0d merges) and %0d clears;", edges_sent,
               merges_made, clears_sent);
      $display("full 1024-node merge, output hold-off and three stall mixes covered.");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/ufem_pkg.sv
sv/union_find_edge_merger_unit.sv
verif/union_find_edge_merger_unit_test.sv
